[rtl/stt_pkg.sv]
`timescale 1ns / 1ps

package stt_pkg;

  localparam int KW_CHARS    = 9;
  localparam int KW_IDX_BITS = $clog2(KW_CHARS);
  localparam int POS_BITS    = 16;
  localparam int KW_TXT_BITS = 128;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic REC_TOKEN   = 1'b0;
  localparam logic REC_CONTENT = 1'b1;

  localparam logic [5:0] K_IDENT     = 6'd0;
  localparam logic [5:0] K_NUMBER    = 6'd1;
  localparam logic [5:0] K_STRING    = 6'd2;
  localparam logic [5:0] K_INT       = 6'd3;
  localparam logic [5:0] K_RETURN    = 6'd4;
  localparam logic [5:0] K_IF        = 6'd5;
  localparam logic [5:0] K_ELSE      = 6'd6;
  localparam logic [5:0] K_WHILE     = 6'd7;
  localparam logic [5:0] K_FOR       = 6'd8;
  localparam logic [5:0] K_SPAWN     = 6'd9;
  localparam logic [5:0] K_YIELD     = 6'd10;
  localparam logic [5:0] K_AWAIT     = 6'd11;
  localparam logic [5:0] K_COROUTINE = 6'd12;
  localparam logic [5:0] K_INCLUDE   = 6'd13;
  localparam logic [5:0] K_PLUS      = 6'd14;
  localparam logic [5:0] K_INC       = 6'd15;
  localparam logic [5:0] K_MINUS     = 6'd16;
  localparam logic [5:0] K_DEC       = 6'd17;
  localparam logic [5:0] K_STAR      = 6'd18;
  localparam logic [5:0] K_SLASH     = 6'd19;
  localparam logic [5:0] K_SEMI      = 6'd20;
  localparam logic [5:0] K_COMMA     = 6'd21;
  localparam logic [5:0] K_LPAREN    = 6'd22;
  localparam logic [5:0] K_RPAREN    = 6'd23;
  localparam logic [5:0] K_LBRACE    = 6'd24;
  localparam logic [5:0] K_RBRACE    = 6'd25;
  localparam logic [5:0] K_ASSIGN    = 6'd26;
  localparam logic [5:0] K_EQ        = 6'd27;
  localparam logic [5:0] K_LT        = 6'd28;
  localparam logic [5:0] K_LE        = 6'd29;
  localparam logic [5:0] K_GT        = 6'd30;
  localparam logic [5:0] K_GE        = 6'd31;
  localparam logic [5:0] K_UNKNOWN   = 6'd32;
  localparam logic [5:0] K_EOF       = 6'd33;
  localparam logic [5:0] K_ERROR     = 6'd34;

  typedef struct packed {
    logic        record_kind;
    logic [5:0]  token_kind;
    logic [15:0] first_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic [7:0]  content_byte;
    logic        last_of_item;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       r0;
    rec_t       r1;
  } lex_out_t;

endpackage

[rtl/stt_lexer.sv]
`timescale 1ns / 1ps

module stt_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        source_byte_i,
  input  logic              end_of_text_i,
  output stt_pkg::lex_out_t lex_o
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_HASH, M_STRING, M_ESC, M_COMMENT, M_OPER
  } mode_e;

  typedef struct packed {
    logic [15:0]         len;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] col;
  } cur_t;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_PLUS   = 3'd1;
  localparam logic [2:0] OP_MINUS  = 3'd2;
  localparam logic [2:0] OP_ASSIGN = 3'd3;
  localparam logic [2:0] OP_LT     = 3'd4;
  localparam logic [2:0] OP_GT     = 3'd5;
  localparam logic [2:0] OP_SLASH  = 3'd6;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [15:0]         LEN_MAX = 16'hFFFF;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic word_is(input logic [KW_CHARS-1:0][7:0] p,
                                   input logic [15:0] len,
                                   input logic [KW_TXT_BITS-1:0] txt, input int n);
    logic ok;
    ok = (len == 16'(n)) && (n <= KW_CHARS);
    for (int i = 0; i < KW_CHARS; i++) begin
      if (i < n) begin
        if (p[i] != txt[8*(n-1-i) +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [KW_CHARS-1:0][7:0] p,
                                            input logic [15:0] len);
    if (word_is(p, len, "int", 3))       return K_INT;
    if (word_is(p, len, "string", 6))    return K_INT;
    if (word_is(p, len, "return", 6))    return K_RETURN;
    if (word_is(p, len, "if", 2))        return K_IF;
    if (word_is(p, len, "else", 4))      return K_ELSE;
    if (word_is(p, len, "while", 5))     return K_WHILE;
    if (word_is(p, len, "for", 3))       return K_FOR;
    if (word_is(p, len, "spawn", 5))     return K_SPAWN;
    if (word_is(p, len, "yield", 5))     return K_YIELD;
    if (word_is(p, len, "await", 5))     return K_AWAIT;
    if (word_is(p, len, "coroutine", 9)) return K_COROUTINE;
    return K_IDENT;
  endfunction

  function automatic logic [5:0] op_single(input logic [2:0] p);
    case (p)
      OP_PLUS:   return K_PLUS;
      OP_MINUS:  return K_MINUS;
      OP_ASSIGN: return K_ASSIGN;
      OP_LT:     return K_LT;
      OP_GT:     return K_GT;
      OP_SLASH:  return K_SLASH;
      default:   return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [5:0] op_double(input logic [2:0] p);
    case (p)
      OP_PLUS:   return K_INC;
      OP_MINUS:  return K_DEC;
      OP_ASSIGN: return K_EQ;
      OP_LT:     return K_LE;
      OP_GT:     return K_GE;
      default:   return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    case (p)
      OP_PLUS:   return "+";
      OP_MINUS:  return "-";
      OP_ASSIGN: return "=";
      OP_LT:     return "=";
      OP_GT:     return "=";
      default:   return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] b);
    case (b)
      "+":     return OP_PLUS;
      "-":     return OP_MINUS;
      "=":     return OP_ASSIGN;
      "<":     return OP_LT;
      ">":     return OP_GT;
      "/":     return OP_SLASH;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    case (b)
      "*":     return K_STAR;
      ";":     return K_SEMI;
      ",":     return K_COMMA;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] b);
    case (b)
      "n":     return CH_LF;
      "t":     return CH_TAB;
      "r":     return CH_CR;
      default: return b;
    endcase
  endfunction

  function automatic cur_t adv_cur(input cur_t c, input logic [7:0] b);
    cur_t r;
    r = c;
    if (b == CH_LF) begin
      if (c.line != POS_MAX) r.line = c.line + POS_ONE;
      r.col = POS_ONE;
    end else if (c.col != POS_MAX) begin
      r.col = c.col + POS_ONE;
    end
    return r;
  endfunction

  function automatic cur_t take_cur(input cur_t c, input logic [7:0] b);
    cur_t r;
    r = adv_cur(c, b);
    if (c.len != LEN_MAX) r.len = c.len + 16'd1;
    return r;
  endfunction

  function automatic logic [15:0] clip_pos(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic rec_t mk_rec(input logic rk, input logic [5:0] kind,
                                  input logic [POS_BITS-1:0] ln,
                                  input logic [POS_BITS-1:0] cl,
                                  input logic [15:0] len, input logic [7:0] byt);
    rec_t r;
    r.record_kind   = rk;
    r.token_kind    = kind;
    r.first_line    = clip_pos(ln);
    r.start_column  = clip_pos(cl);
    r.lexeme_length = len;
    r.content_byte  = byt;
    r.last_of_item  = 1'b0;
    return r;
  endfunction

  mode_e                     mode_q, mode_d;
  logic [2:0]                pend_q, pend_d;
  cur_t                      cur_q, cur_d;
  logic [POS_BITS-1:0]       tline_q, tline_d, tcol_q, tcol_d;
  logic [KW_CHARS-1:0][7:0]  pfx_q;
  logic                      pfx_we;
  logic [KW_IDX_BITS-1:0]    pfx_idx;

  logic       eot, fall;
  logic [7:0] b;
  logic [2:0] p;
  logic [5:0] wkind;
  logic [1:0] n_c;
  rec_t       r0_c, r1_c, em;
  mode_e      nmode;
  logic [2:0] nop;

  always_comb begin
    case (mode_q)
      M_IDENT:  wkind = ident_kind(pfx_q, cur_q.len);
      M_NUMBER: wkind = K_NUMBER;
      M_HASH:   wkind = word_is(pfx_q, cur_q.len, "#include", 8) ? K_INCLUDE : K_UNKNOWN;
      default:  wkind = op_single((pend_q < 3'd7) ? pend_q : OP_NONE);
    endcase
  end

  always_comb begin
    b       = source_byte_i;
    eot     = end_of_text_i || (source_byte_i == 8'h00);
    mode_d  = mode_q;
    pend_d  = pend_q;
    cur_d   = cur_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    pfx_we  = 1'b0;
    pfx_idx = '0;
    n_c     = 2'd0;
    r0_c    = '0;
    r1_c    = '0;
    em      = '0;
    fall    = 1'b0;
    p       = (pend_q < 3'd7) ? pend_q : OP_NONE;
    nmode   = M_IDLE;
    nop     = OP_NONE;

    if (eot) begin
      if (mode_q == M_STRING || mode_q == M_ESC) begin
        r0_c = mk_rec(REC_TOKEN, K_ERROR, tline_q, tcol_q, cur_q.len, 8'h00);
        n_c  = 2'd1;
      end else begin
        if (mode_q == M_IDENT || mode_q == M_NUMBER || mode_q == M_HASH ||
            mode_q == M_OPER) begin
          r0_c = mk_rec(REC_TOKEN, wkind, tline_q, tcol_q, cur_q.len, 8'h00);
          n_c  = 2'd1;
        end
        em = mk_rec(REC_TOKEN, K_EOF, cur_q.line, cur_q.col, 16'd0, 8'h00);
        if (n_c == 2'd0) r0_c = em; else r1_c = em;
        n_c = n_c + 2'd1;
      end
      mode_d    = M_IDLE;
      pend_d    = OP_NONE;
      cur_d.len = 16'd0;
      cur_d.line = POS_ONE;
      cur_d.col  = POS_ONE;
      tline_d   = POS_ONE;
      tcol_d    = POS_ONE;
    end else begin
      case (mode_q)
        M_STRING: begin
          if (cur_d.len < 16'(KW_CHARS)) begin
            pfx_we = 1'b1; pfx_idx = cur_d.len[KW_IDX_BITS-1:0];
          end
          cur_d = take_cur(cur_d, b);
          if (b == CH_QUOTE) begin
            r0_c   = mk_rec(REC_TOKEN, K_STRING, tline_d, tcol_d, cur_d.len, 8'h00);
            n_c    = 2'd1;
            mode_d = M_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_d = M_ESC;
          end else begin
            r0_c = mk_rec(REC_CONTENT, K_STRING, tline_d, tcol_d, 16'd0, b);
            n_c  = 2'd1;
          end
        end
        M_ESC: begin
          if (cur_d.len < 16'(KW_CHARS)) begin
            pfx_we = 1'b1; pfx_idx = cur_d.len[KW_IDX_BITS-1:0];
          end
          cur_d  = take_cur(cur_d, b);
          r0_c   = mk_rec(REC_CONTENT, K_STRING, tline_d, tcol_d, 16'd0, decode_escape(b));
          n_c    = 2'd1;
          mode_d = M_STRING;
        end
        M_COMMENT: begin
          if (b == CH_LF) begin
            mode_d = M_IDLE;
            fall   = 1'b1;
          end else begin
            cur_d = adv_cur(cur_d, b);
          end
        end
        M_IDENT, M_NUMBER, M_HASH: begin
          if ((mode_q == M_IDENT && (is_alpha(b) || is_digit(b) || b == CH_UNDER)) ||
              (mode_q == M_NUMBER && is_digit(b)) ||
              (mode_q == M_HASH && is_alpha(b))) begin
            if (cur_d.len < 16'(KW_CHARS)) begin
              pfx_we = 1'b1; pfx_idx = cur_d.len[KW_IDX_BITS-1:0];
            end
            cur_d = take_cur(cur_d, b);
          end else begin
            fall = 1'b1;
          end
        end
        M_OPER: begin
          if (p == OP_SLASH && b == "/") begin
            if (cur_d.len < 16'(KW_CHARS)) begin
              pfx_we = 1'b1; pfx_idx = cur_d.len[KW_IDX_BITS-1:0];
            end
            cur_d  = take_cur(cur_d, b);
            mode_d = M_COMMENT;
          end else if (p != OP_NONE && op_second(p) != 8'h00 && b == op_second(p)) begin
            if (cur_d.len < 16'(KW_CHARS)) begin
              pfx_we = 1'b1; pfx_idx = cur_d.len[KW_IDX_BITS-1:0];
            end
            cur_d  = take_cur(cur_d, b);
            r0_c   = mk_rec(REC_TOKEN, op_double(p), tline_d, tcol_d, cur_d.len, 8'h00);
            n_c    = 2'd1;
            mode_d = M_IDLE;
          end else begin
            fall = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE;
          fall   = 1'b1;
        end
      endcase

      if (fall) begin
        if (mode_d != M_IDLE) begin
          r0_c = mk_rec(REC_TOKEN, wkind, tline_q, tcol_q, cur_q.len, 8'h00);
          n_c  = 2'd1;
        end
        mode_d = M_IDLE;
        pend_d = OP_NONE;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
          cur_d = adv_cur(cur_d, b);
        end else begin
          if (b == CH_HASH)                    nmode = M_HASH;
          else if (is_alpha(b) || b == CH_UNDER) nmode = M_IDENT;
          else if (is_digit(b))                nmode = M_NUMBER;
          else if (b == CH_QUOTE)              nmode = M_STRING;
          else if (op_code(b) != OP_NONE) begin
            nmode = M_OPER;
            nop   = op_code(b);
          end
          tline_d   = cur_d.line;
          tcol_d    = cur_d.col;
          cur_d.len = 16'd0;
          mode_d    = nmode;
          if (nmode == M_OPER) pend_d = nop;
          pfx_we  = 1'b1;
          pfx_idx = '0;
          cur_d   = take_cur(cur_d, b);
          if (nmode == M_IDLE) begin
            em = mk_rec(REC_TOKEN, single_kind(b), tline_d, tcol_d, cur_d.len, 8'h00);
            if (n_c == 2'd0) r0_c = em; else r1_c = em;
            n_c = n_c + 2'd1;
          end
        end
      end
    end

    r0_c.last_of_item = (n_c == 2'd1);
    r1_c.last_of_item = 1'b1;
  end

  assign lex_o.count = n_c;
  assign lex_o.r0    = r0_c;
  assign lex_o.r1    = r1_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      pend_q     <= OP_NONE;
      cur_q.len  <= 16'd0;
      cur_q.line <= POS_ONE;
      cur_q.col  <= POS_ONE;
      tline_q    <= POS_ONE;
      tcol_q     <= POS_ONE;
    end else if (take_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      cur_q   <= cur_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && pfx_we) pfx_q[pfx_idx] <= b;
  end

endmodule

[rtl/stt_fifo.sv]
`timescale 1ns / 1ps

module stt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stt_pkg::lex_out_t lex_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output stt_pkg::rec_t     rec_o
);
  import stt_pkg::*;

  rec_t                     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] rd_q, wr_q;
  logic [FIFO_CNT_BITS-1:0] cnt_q;
  logic [1:0]               wr_n;
  logic                     pop;
  logic [FIFO_PTR_BITS-1:0] wr_nxt;

  assign wr_n    = push_i ? lex_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign rec_o   = mem_q[rd_q];
  assign wr_nxt  = wr_q + FIFO_PTR_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (pop) rd_q <= rd_q + FIFO_PTR_BITS'(1);
      wr_q  <= wr_q + FIFO_PTR_BITS'(wr_n);
      cnt_q <= cnt_q + FIFO_CNT_BITS'(wr_n) - FIFO_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) mem_q[wr_q] <= lex_i.r0;
    if (wr_n == 2'd2) mem_q[wr_nxt] <= lex_i.r1;
  end

endmodule

[rtl/source_text_tokenizer_unit.sv]
// A word is formed combinationally and written into the four-entry output queue when its
// source byte is taken. Throughput: one source byte per cycle while two queue entries are
// free; each byte yields up to two words, drained one per cycle while out_ready_i is high.
// Reset: position returns to line 1 column 1, scanner goes idle, output queue empties.
// The end flag or a NUL byte flushes the pending token and resets the position the same way.
`timescale 1ns / 1ps

module source_text_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_kind_o,
  output logic [5:0]  token_kind_o,
  output logic [15:0] first_line_o,
  output logic [15:0] start_column_o,
  output logic [15:0] lexeme_length_o,
  output logic [7:0]  content_byte_o,
  output logic        last_of_item_o
);
  import stt_pkg::*;

  lex_out_t lex;
  rec_t     rec;
  logic     take;

  assign take = in_valid_i && in_ready_o;

  stt_lexer u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .source_byte_i (source_byte_i),
    .end_of_text_i (end_of_text_i),
    .lex_o         (lex)
  );

  stt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .lex_i   (lex),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rec_o   (rec)
  );

  assign record_kind_o   = rec.record_kind;
  assign token_kind_o    = rec.token_kind;
  assign first_line_o    = rec.first_line;
  assign start_column_o  = rec.start_column;
  assign lexeme_length_o = rec.lexeme_length;
  assign content_byte_o  = rec.content_byte;
  assign last_of_item_o  = rec.last_of_item;

endmodule

[rtl/stt_checker.sv]
`timescale 1ns / 1ps

module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        record_kind_o,
  input logic [5:0]  token_kind_o,
  input logic [15:0] first_line_o,
  input logic [15:0] start_column_o,
  input logic [15:0] lexeme_length_o,
  input logic [7:0]  content_byte_o,
  input logic        last_of_item_o
);
  import stt_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(lexeme_length_o) && $stable(content_byte_o) && $stable(last_of_item_o))
    else $error("output word changed while stalled");

  a_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == REC_CONTENT |->
    token_kind_o == K_STRING && lexeme_length_o == 16'd0 && !last_of_item_o ||
    out_valid_o && record_kind_o == REC_CONTENT && token_kind_o == K_STRING &&
    lexeme_length_o == 16'd0)
    else $error("malformed content word");

  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == REC_TOKEN && token_kind_o == K_EOF |->
    lexeme_length_o == 16'd0 && last_of_item_o)
    else $error("end-of-file word malformed");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> first_line_o != 16'd0 && start_column_o != 16'd0)
    else $error("zero position");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == REC_TOKEN && token_kind_o != K_EOF &&
    token_kind_o != K_ERROR |-> lexeme_length_o != 16'd0)
    else $error("empty token");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);

[tb/tb_source_text_tokenizer_unit.sv]
`timescale 1ns / 1ps

module tb_source_text_tokenizer_unit;
  import stt_pkg::*;

  typedef enum int {
    SM_IDLE, SM_IDENT, SM_NUMBER, SM_HASH, SM_STRING, SM_ESC, SM_COMMENT, SM_OPER
  } scan_e;

  typedef struct {
    logic [7:0] src;
    logic       eot;
    logic       drain;
  } src_word_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 100;
  localparam int UMAX         = 65535;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  source_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        record_kind;
  logic [5:0]  token_kind;
  logic [15:0] first_line;
  logic [15:0] start_column;
  logic [15:0] lexeme_length;
  logic [7:0]  content_byte;
  logic        last_of_item;

  source_text_tokenizer_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .source_byte_i  (source_byte),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .record_kind_o  (record_kind),
    .token_kind_o   (token_kind),
    .first_line_o   (first_line),
    .start_column_o (start_column),
    .lexeme_length_o(lexeme_length),
    .content_byte_o (content_byte),
    .last_of_item_o (last_of_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  src_word_t   pending_q[$];
  rec_t        token_q[$];
  int          n_sent, n_checked, n_content, n_errors, cycles;
  logic        quiet = 1'b0;

  scan_e       mode;
  int          oper;
  logic [7:0]  prefix[KW_CHARS];
  int          tok_len, tok_line, tok_col, line_no, col_no;

  function automatic void lexer_reset();
    mode = SM_IDLE;
    oper = 0;
    tok_len = 0;
    tok_line = 1;
    tok_col = 1;
    line_no = 1;
    col_no = 1;
  endfunction

  function automatic void push_token(logic rk, logic [5:0] kind, int len, logic [7:0] cb);
    rec_t r;
    r.record_kind   = rk;
    r.token_kind    = kind;
    r.first_line    = 16'(tok_line);
    r.start_column  = 16'(tok_col);
    r.lexeme_length = 16'(len);
    r.content_byte  = cb;
    r.last_of_item  = 1'b0;
    token_q.insert(token_q.size(), r);
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void advance(logic [7:0] b);
    if (b == 8'h0a) begin
      if (line_no < UMAX) line_no++;
      col_no = 1;
    end else if (col_no < UMAX) begin
      col_no++;
    end
  endfunction

  function automatic void take(logic [7:0] b);
    if (tok_len < KW_CHARS) prefix[tok_len] = b;
    if (tok_len < UMAX) tok_len++;
    advance(b);
  endfunction

  function automatic void open_token(scan_e m);
    tok_line = line_no;
    tok_col = col_no;
    tok_len = 0;
    mode = m;
  endfunction

  function automatic bit prefix_matches(string kw);
    if (tok_len != kw.len() || kw.len() > KW_CHARS) return 1'b0;
    for (int i = 0; i < kw.len(); i++) if (prefix[i] != kw[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] oper_char(int p);
    case (p)
      1: return "+";
      2: return "-";
      3: return "=";
      4: return "<";
      5: return ">";
      6: return "/";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [5:0] oper_single(int p);
    case (p)
      1: return K_PLUS;
      2: return K_MINUS;
      3: return K_ASSIGN;
      4: return K_LT;
      5: return K_GT;
      6: return K_SLASH;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [5:0] oper_double(int p);
    case (p)
      1: return K_INC;
      2: return K_DEC;
      3: return K_EQ;
      4: return K_LE;
      5: return K_GE;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [7:0] oper_second(int p);
    case (p)
      1: return "+";
      2: return "-";
      3, 4, 5: return "=";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    case (mode)
      SM_IDENT: begin
        if (prefix_matches("int") || prefix_matches("string")) return K_INT;
        if (prefix_matches("return")) return K_RETURN;
        if (prefix_matches("if")) return K_IF;
        if (prefix_matches("else")) return K_ELSE;
        if (prefix_matches("while")) return K_WHILE;
        if (prefix_matches("for")) return K_FOR;
        if (prefix_matches("spawn")) return K_SPAWN;
        if (prefix_matches("yield")) return K_YIELD;
        if (prefix_matches("await")) return K_AWAIT;
        if (prefix_matches("coroutine")) return K_COROUTINE;
        return K_IDENT;
      end
      SM_NUMBER: return K_NUMBER;
      SM_HASH: return prefix_matches("#include") ? K_INCLUDE : K_UNKNOWN;
      default: return oper_single(oper);
    endcase
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] b);
    case (b)
      "*": return K_STAR;
      ";": return K_SEMI;
      ",": return K_COMMA;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic void scan_idle(logic [7:0] b);
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
      advance(b);
      return;
    end
    if (b == "#") begin open_token(SM_HASH); take(b); return; end
    if (is_alpha(b) || b == "_") begin open_token(SM_IDENT); take(b); return; end
    if (is_digit(b)) begin open_token(SM_NUMBER); take(b); return; end
    if (b == 8'h22) begin open_token(SM_STRING); take(b); return; end
    for (int i = 1; i < 7; i++) begin
      if (b == oper_char(i)) begin
        open_token(SM_OPER);
        oper = i;
        take(b);
        return;
      end
    end
    open_token(SM_IDLE);
    take(b);
    push_token(REC_TOKEN, single_kind(b), tok_len, 8'd0);
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic eot);
    int  n0;
    bit  fall;
    n0 = token_q.size();
    fall = 1'b0;
    if (eot || b == 8'd0) begin
      if (mode == SM_STRING || mode == SM_ESC) begin
        push_token(REC_TOKEN, K_ERROR, tok_len, 8'd0);
      end else begin
        if (mode inside {SM_IDENT, SM_NUMBER, SM_HASH, SM_OPER})
          push_token(REC_TOKEN, word_kind(), tok_len, 8'd0);
        tok_line = line_no;
        tok_col = col_no;
        push_token(REC_TOKEN, K_EOF, 0, 8'd0);
      end
      lexer_reset();
    end else begin
      case (mode)
        SM_STRING: begin
          take(b);
          if (b == 8'h22) begin
            push_token(REC_TOKEN, K_STRING, tok_len, 8'd0);
            mode = SM_IDLE;
          end else if (b == 8'h5c) begin
            mode = SM_ESC;
          end else begin
            push_token(REC_CONTENT, K_STRING, 0, b);
          end
        end
        SM_ESC: begin
          take(b);
          push_token(REC_CONTENT, K_STRING, 0,
                     b == "n" ? 8'h0a : b == "t" ? 8'h09 : b == "r" ? 8'h0d : b);
          mode = SM_STRING;
        end
        SM_COMMENT: begin
          if (b == 8'h0a) begin
            mode = SM_IDLE;
            fall = 1'b1;
          end else begin
            advance(b);
          end
        end
        SM_IDENT: if (is_alpha(b) || is_digit(b) || b == "_") take(b); else fall = 1'b1;
        SM_NUMBER: if (is_digit(b)) take(b); else fall = 1'b1;
        SM_HASH: if (is_alpha(b)) take(b); else fall = 1'b1;
        SM_OPER: begin
          if (oper == 6 && b == "/") begin
            take(b);
            mode = SM_COMMENT;
          end else if (oper_second(oper) != 8'd0 && b == oper_second(oper)) begin
            take(b);
            push_token(REC_TOKEN, oper_double(oper), tok_len, 8'd0);
            mode = SM_IDLE;
          end else begin
            fall = 1'b1;
          end
        end
        default: begin
          mode = SM_IDLE;
          fall = 1'b1;
        end
      endcase
      if (fall) begin
        if (mode != SM_IDLE) begin
          push_token(REC_TOKEN, word_kind(), tok_len, 8'd0);
          mode = SM_IDLE;
        end
        oper = 0;
        scan_idle(b);
      end
    end
    if (token_q.size() > n0) token_q[token_q.size() - 1].last_of_item = 1'b1;
  endfunction

  task automatic add_byte(logic [7:0] b, logic eot = 1'b0, logic drain = 1'b0);
    src_word_t w;
    w.src = b;
    w.eot = eot;
    w.drain = drain;
    pending_q.insert(pending_q.size(), w);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_fragment();
    string kw[12] = '{"int", "string", "return", "if", "else", "while", "for", "spawn",
                      "yield", "await", "coroutine", "coroutines"};
    string ops[14] = '{"+", "++", "-", "--", "=", "==", "<", "<=", ">", ">=", "/", "*",
                       ";", "(){},"};
    int    sel;
    int    n;
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1, 2: add_text(kw[$urandom_range(0, 11)]);
      3, 4: begin
        n = $urandom_range(1, 12);
        add_byte($urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25)));
        repeat (n - 1) add_byte($urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9))
                                                         : 8'("A" + $urandom_range(0, 25)));
      end
      5: repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(0, 9)));
      6, 7: begin
        add_byte(8'h22);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_byte(8'h5c);
            add_byte(8'($urandom_range(1, 255)));
          end else begin
            add_byte($urandom_range(32, 126) == 8'h22 ? "q" : 8'($urandom_range(1, 255)));
          end
        end
        add_byte(8'h22);
      end
      8, 9, 10: add_text(ops[$urandom_range(0, 13)]);
      11: begin
        add_text("//");
        repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)));
        add_byte(8'h0a);
      end
      12: begin
        if ($urandom_range(0, 1) != 0) add_text("#include");
        else add_text("#defn");
      end
      13, 14: add_byte($urandom_range(0, 1) ? 8'h0a : " ");
      15, 16: add_byte(8'($urandom_range(1, 255)));
      17: add_byte(8'($urandom_range(0, 255)), 1'b1);
      18: add_byte(8'd0);
      default: add_byte(8'h09);
    endcase
    if ($urandom_range(0, 2) != 0) add_byte(" ");
  endtask

  always @(posedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    logic       nxt_eot;
    int         gap;
    nxt_valid = in_valid;
    nxt_byte = source_byte;
    nxt_eot = end_of_text;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_tokens(source_byte, end_of_text);
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && token_q.size() > 0)) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13) - 1;
          end else begin
            nxt_valid = 1'b1;
            nxt_byte = pending_q[0].src;
            nxt_eot = pending_q[0].eot;
            void'(pending_q.pop_front());
          end
        end
      end
    end
    in_valid <= nxt_valid;
    source_byte <= nxt_byte;
    end_of_text <= nxt_eot;
  end

  always @(posedge clk) begin
    int   stall;
    int   hold;
    bit   held;
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (hold > 0) begin
      hold--;
      nxt_ready = 1'b0;
    end else if (!held && n_sent >= 250) begin
      held = 1'b1;
      hold = LONG_HOLD - 1;
      nxt_ready = 1'b0;
    end else if (stall > 0) begin
      stall--;
      nxt_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall = $urandom_range(1, 13) - 1;
      nxt_ready = 1'b0;
    end
    out_ready <= rst_n ? nxt_ready : 1'b0;
  end

  always @(posedge clk) begin
    rec_t want;
    rec_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{record_kind, token_kind, first_line, start_column, lexeme_length,
              content_byte, last_of_item};
      if (token_q.size() == 0) begin
        $display("%0t: unexpected word rk=%0d kind=%0d line=%0d col=%0d len=%0d byte=%0d last=%0d",
                 $time, got.record_kind, got.token_kind, got.first_line, got.start_column,
                 got.lexeme_length, got.content_byte, got.last_of_item);
        n_errors++;
      end else begin
        want = token_q.pop_front();
        n_checked++;
        if (want.record_kind == REC_CONTENT) n_content++;
        if (got != want) begin
          $display("%0t: mismatch exp rk=%0d kind=%0d line=%0d col=%0d len=%0d byte=%0d last=%0d",
                   $time, want.record_kind, want.token_kind, want.first_line,
                   want.start_column, want.lexeme_length, want.content_byte,
                   want.last_of_item);
          $display("%0t:          got rk=%0d kind=%0d line=%0d col=%0d len=%0d byte=%0d last=%0d",
                   $time, got.record_kind, got.token_kind, got.first_line, got.start_column,
                   got.lexeme_length, got.content_byte, got.last_of_item);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d words still expected", $time, token_q.size());
      $display("[source_text_tokenizer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    lexer_reset();
    add_text("#include \"a\\n\\t\\r\\q\" x_1 9a ");
    add_byte(8'hff);
    add_text("+++--==<=>=//c\n*;,(){}#zz@");
    add_byte(8'd0);
    add_text("\"ab\\");
    add_byte(8'h41, 1'b1);
    while (pending_q.size() < 650) begin
      if (pending_q.size() > 400 && pending_q.size() < 420) add_byte(" ", 1'b0, 1'b1);
      add_fragment();
    end
    add_byte(8'd0, 1'b1);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 60) @(posedge clk);
    quiet = 1'b1;
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d source bytes; checked %0d output words, %0d of them string content",
             n_sent, n_checked, n_content);
    if (n_errors == 0 && token_q.size() == 0) begin
      $display("[source_text_tokenizer_unit] OK");
    end else begin
      $display("[source_text_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/stt_pkg.sv
rtl/stt_lexer.sv
rtl/stt_fifo.sv
rtl/source_text_tokenizer_unit.sv
rtl/stt_checker.sv
tb/tb_source_text_tokenizer_unit.sv
